@@ rtl/bapt_pkg.sv @@
package bapt_pkg;

  // field widths fixed by the item format
  localparam int unsigned STAMP_BITS     = 32;
  localparam int unsigned SAMPLE_BITS    = 12;
  localparam int unsigned TICK_US_BITS   = 10;
  localparam int unsigned US_BITS        = 16;
  localparam int unsigned PROD_BITS      = US_BITS + TICK_US_BITS;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned NUM_LANES      = 3;

  // reset values
  localparam logic [TICK_US_BITS-1:0] TICK_US_RESET = TICK_US_BITS'(10);
  localparam logic [US_BITS-1:0]      REST_RESET    = US_BITS'(500);

  // command queue between front and back
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QIDX_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

  // request type codes on the input channel
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_RISE   = 2'd1;
  localparam logic [1:0] REQ_FALL   = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [STAMP_BITS-1:0]  timestamp;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
  } req_t;

  typedef struct packed {
    logic [US_BITS-1:0]     high_time_us;
    logic                   high_time_valid;
    logic [US_BITS-1:0]     low_time_us;
    logic [SAMPLE_BITS-1:0] average_a;
    logic [SAMPLE_BITS-1:0] average_b;
    logic [SAMPLE_BITS-1:0] average_c;
    logic                   averages_valid;
  } res_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_RISE,
    CMD_FALL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [STAMP_BITS-1:0]  timestamp;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

@@ rtl/bapt_if.sv @@
// request channel
interface bapt_req_if;
  import bapt_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// result channel
interface bapt_res_if;
  import bapt_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// register write channel
interface bapt_cfg_if;
  import bapt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TICK_US_BITS-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/bapt_front.sv @@
module bapt_front (
  bapt_req_if.sink       req_i,
  output logic           push_o,
  output bapt_pkg::cmd_t push_data_o,
  input  logic           full_i
);
  import bapt_pkg::*;

  logic known;

  // take an item whenever the queue has room
  assign req_i.ready = !full_i;

  // classify the request; unknown types are taken and dropped
  always_comb begin
    known                 = 1'b1;
    push_data_o.kind      = CMD_SAMPLE;
    push_data_o.timestamp = req_i.payload.timestamp;
    push_data_o.sample_a  = req_i.payload.sample_a;
    push_data_o.sample_b  = req_i.payload.sample_b;
    push_data_o.sample_c  = req_i.payload.sample_c;
    case (req_i.payload.req_type)
      REQ_SAMPLE: push_data_o.kind = CMD_SAMPLE;
      REQ_RISE:   push_data_o.kind = CMD_RISE;
      REQ_FALL:   push_data_o.kind = CMD_FALL;
      default:    known = 1'b0;
    endcase
  end

  assign push_o = req_i.valid && !full_i && known;

endmodule

@@ rtl/bapt_queue.sv @@
module bapt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bapt_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output bapt_pkg::cmd_t pop_data_o,
  output logic           empty_o
);
  import bapt_pkg::*;

  cmd_t                 mem_q [QDEPTH];
  logic [QIDX_BITS-1:0] wptr_q, wptr_d;
  logic [QIDX_BITS-1:0] rptr_q, rptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;

  assign full_o     = (count_q == QCNT_BITS'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QIDX_BITS'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QIDX_BITS'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // fill count follows a push without a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a push");

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

@@ rtl/bapt_back.sv @@
module bapt_back #(
  parameter int unsigned COUNT_BITS = bapt_pkg::COUNT_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bapt_cfg_if.sink       cfg_i,
  input  logic           empty_i,
  input  bapt_pkg::cmd_t pop_data_i,
  output logic           pop_o,
  bapt_res_if.source     res_o
);
  import bapt_pkg::*;

  localparam int unsigned SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  back_state_e             state_q, state_d;
  logic [TICK_US_BITS-1:0] tick_us_q;
  logic [SUM_BITS-1:0]     sum_q [NUM_LANES];
  logic [SUM_BITS-1:0]     sum_d [NUM_LANES];
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic [STAMP_BITS-1:0]   rise_q, rise_d;
  logic [STAMP_BITS-1:0]   fall_q, fall_d;
  logic                    fall_seen_q, fall_seen_d;
  logic [US_BITS-1:0]      rest_us_q, rest_us_d;
  logic                    out_valid_q, out_valid_d;

  logic [US_BITS-1:0]      high_us_q, high_us_d;
  logic                    high_valid_q, high_valid_d;
  logic [SUM_BITS-1:0]     quo_q [NUM_LANES];
  logic [SUM_BITS-1:0]     quo_d [NUM_LANES];
  logic [COUNT_BITS-1:0]   rem_q [NUM_LANES];
  logic [COUNT_BITS-1:0]   rem_d [NUM_LANES];
  logic [STEP_BITS-1:0]    step_q, step_d;
  res_t                    out_q, out_d;

  logic [SAMPLE_BITS-1:0]  smp [NUM_LANES];
  logic [COUNT_BITS:0]     rem_shift [NUM_LANES];
  logic [COUNT_BITS:0]     rem_diff [NUM_LANES];
  logic [US_BITS-1:0]      ticks_lo;
  logic [PROD_BITS-1:0]    prod;
  logic                    load_res;
  logic                    have_avg;

  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  assign smp[0] = pop_data_i.sample_a;
  assign smp[1] = pop_data_i.sample_b;
  assign smp[2] = pop_data_i.sample_c;

  // tick difference to microseconds, low 16 bits only
  always_comb begin
    if (pop_data_i.kind == CMD_FALL) begin
      ticks_lo = pop_data_i.timestamp[US_BITS-1:0] - rise_q[US_BITS-1:0];
    end else begin
      ticks_lo = pop_data_i.timestamp[US_BITS-1:0] - fall_q[US_BITS-1:0];
    end
    prod = PROD_BITS'(ticks_lo) * PROD_BITS'(tick_us_q);
  end

  // one restoring division step per cycle in each lane
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      rem_shift[i] = {rem_q[i], quo_q[i][SUM_BITS-1]};
      rem_diff[i]  = rem_shift[i] - {1'b0, count_q};
    end
  end

  assign have_avg = (count_q != '0);

  // sequencer: execute one command, run division on a fall
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rise_d       = rise_q;
    fall_d       = fall_q;
    fall_seen_d  = fall_seen_q;
    rest_us_d    = rest_us_q;
    high_us_d    = high_us_q;
    high_valid_d = high_valid_q;
    step_d       = step_q;
    pop_o        = 1'b0;
    load_res     = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_d[i] = sum_q[i];
      quo_d[i] = quo_q[i];
      rem_d[i] = rem_q[i];
    end

    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (pop_data_i.kind)
            CMD_SAMPLE: begin
              if (count_q != COUNT_MAX) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                  sum_d[i] = sum_q[i] + SUM_BITS'(smp[i]);
                end
                count_d = count_q + 1'b1;
              end
            end
            CMD_RISE: begin
              if (fall_seen_q) begin
                rest_us_d = prod[US_BITS-1:0];
              end
              rise_d  = pop_data_i.timestamp;
              count_d = '0;
              for (int i = 0; i < NUM_LANES; i++) begin
                sum_d[i] = '0;
              end
            end
            CMD_FALL: begin
              high_valid_d = (pop_data_i.timestamp != rise_q);
              high_us_d    = high_valid_d ? prod[US_BITS-1:0] : '0;
              fall_d       = pop_data_i.timestamp;
              fall_seen_d  = 1'b1;
              step_d       = STEP_BITS'(SUM_BITS - 1);
              for (int i = 0; i < NUM_LANES; i++) begin
                quo_d[i] = sum_q[i];
                rem_d[i] = '0;
              end
              state_d = BK_DIV;
            end
            default: ;
          endcase
        end
      end
      BK_DIV: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          if (!rem_diff[i][COUNT_BITS]) begin
            rem_d[i] = rem_diff[i][COUNT_BITS-1:0];
            quo_d[i] = {quo_q[i][SUM_BITS-2:0], 1'b1};
          end else begin
            rem_d[i] = rem_shift[i][COUNT_BITS-1:0];
            quo_d[i] = {quo_q[i][SUM_BITS-2:0], 1'b0};
          end
        end
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          load_res = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // result register contents
  always_comb begin
    out_d                 = out_q;
    if (load_res) begin
      out_d.high_time_us    = high_us_q;
      out_d.high_time_valid = high_valid_q;
      out_d.low_time_us     = rest_us_q;
      out_d.average_a       = have_avg ? quo_q[0][SAMPLE_BITS-1:0] : '0;
      out_d.average_b       = have_avg ? quo_q[1][SAMPLE_BITS-1:0] : '0;
      out_d.average_c       = have_avg ? quo_q[2][SAMPLE_BITS-1:0] : '0;
      out_d.averages_valid  = have_avg;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control and burst state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      tick_us_q   <= TICK_US_RESET;
      count_q     <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      fall_seen_q <= 1'b0;
      rest_us_q   <= REST_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      fall_seen_q <= fall_seen_d;
      rest_us_q   <= rest_us_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NUM_LANES; i++) begin
        sum_q[i] <= sum_d[i];
      end
      if (cfg_i.valid) begin
        tick_us_q <= cfg_i.data;
      end
    end
  end

  // division and result datapath
  always_ff @(posedge clk_i) begin
    high_us_q    <= high_us_d;
    high_valid_q <= high_valid_d;
    step_q       <= step_d;
    out_q        <= out_d;
    for (int i = 0; i < NUM_LANES; i++) begin
      quo_q[i] <= quo_d[i];
      rem_q[i] <= rem_d[i];
    end
  end

  // division starts only from a fall command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE && state_d == BK_DIV) |-> (pop_o && pop_data_i.kind == CMD_FALL))
    else $error("division started without a fall");

  // divisor holds while the division runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |=> $stable(count_q))
    else $error("burst count changed during division");

  // a loaded result flags averages from the current burst count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> (out_valid_q && out_q.averages_valid == (count_q != '0)))
    else $error("result averages flag does not match burst count");

endmodule

@@ rtl/burst_average_and_pulse_timer.sv @@
// channel  | role   | handshake     | carries
// req_i    | sink   | valid / ready | req_type, timestamp, sample_a/b/c
// res_o    | source | valid / ready | high/low times in us, three averages, flags
// cfg_i    | sink   | valid / ready | tick_microseconds (always ready)
//
// the front takes an item whenever its two-entry command queue has room;
// type 3 items are taken and dropped there
// the back runs samples and rises in its idle state; a fall runs SAMPLE_BITS +
// COUNT_BITS division steps (28 at default) in the bit-per-cycle divider and
// then loads the output register
// reset: tick_microseconds 10, stored low time 500 us, sums and stamps zero
// a stalled result only holds the back at its load step; the queue keeps filling until full
module burst_average_and_pulse_timer #(
  parameter int unsigned COUNT_BITS = bapt_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bapt_req_if.sink   req_i,
  bapt_cfg_if.sink   cfg_i,
  bapt_res_if.source res_o
);
  import bapt_pkg::*;

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t pop_data;
  logic empty;

  // accept and classify
  bapt_front u_front (
    .req_i       (req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // command queue
  bapt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // execute, divide and hold results
  bapt_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule
